// ===== hw/rtl/ut2c_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ut2c_pkg
// Field types and fixed calendar constants for the seconds-to-calendar block.
// ----------------------------------------------------------------------------
package ut2c_pkg;

    // Field types of the input and result items.
    typedef logic        [31:0] t_seconds_count;
    typedef logic signed [7:0]  t_year_offset;
    typedef logic        [3:0]  t_month;
    typedef logic        [4:0]  t_day;
    typedef logic        [4:0]  t_hour;
    typedef logic        [5:0]  t_minute;
    typedef logic        [5:0]  t_second;
    typedef logic        [2:0]  t_weekday;

    // Year that year_offset is measured from.
    localparam int C_BASE_YEAR = 2000;

    // One day is 675 << 7 seconds, so the low seven bits skip the divider.
    localparam int C_TS_W        = 32;
    localparam int C_SUBDAY_BITS = 7;
    localparam int C_DAY_DIV     = 675;

    // Day count at which the Gregorian alpha term steps from 16 to 17.
    localparam logic [15:0] C_ALPHA_STEP_DAYS = 16'd47541;

    // The 1970 epoch falls on a Thursday.
    localparam logic [15:0] C_WD_BIAS = 16'd4;

    // The Meeus B term is the day count plus this, plus the alpha step.
    localparam logic [22:0] C_JD_B_BASE = 23'd2442125;

    // The C term is C_CEN_BASE plus (4 * (days + step) + C_CEN_BIAS) / 1461.
    localparam logic [17:0] C_CEN_BIAS  = 18'd1226;
    localparam logic [12:0] C_CEN_BASE  = 13'd6685;
    localparam logic [23:0] C_CYCLE_DAYS = 24'd1461;

    // The E term is (B - D) * 10000 / 306001.
    localparam logic [22:0] C_E_NUM = 23'd10000;
    localparam int          C_E_DEN = 306001;

    // Year subtrahends for months after and up to February.
    localparam logic [15:0] C_YEAR_SUB_LATE  = 16'(4716 + C_BASE_YEAR);
    localparam logic [15:0] C_YEAR_SUB_EARLY = 16'(4715 + C_BASE_YEAR);

    // Days before month term E, that is floor(30.6001 * e).
    function automatic logic [8:0] f_month_start(input logic [3:0] e);
        logic [8:0] v;
        case (e)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd30;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd91;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd183;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd244;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd336;
            4'd12:   v = 9'd367;
            4'd13:   v = 9'd397;
            4'd14:   v = 9'd428;
            default: v = 9'd459;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/ut2c_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ut2c_in_if
// Valid/ready channel that carries one seconds count per item.
// ----------------------------------------------------------------------------
interface ut2c_in_if;
    import ut2c_pkg::*;

    logic           valid;
    logic           ready;
    t_seconds_count seconds_count;

    modport source (output valid, output seconds_count, input ready);
    modport sink   (input valid, input seconds_count, output ready);
endinterface

// ===== hw/rtl/ut2c_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ut2c_out_if
// Valid/ready channel that carries one set of calendar fields per item.
// ----------------------------------------------------------------------------
interface ut2c_out_if;
    import ut2c_pkg::*;

    logic         valid;
    logic         ready;
    t_year_offset year_offset;
    t_month       month;
    t_day         day_of_month;
    t_hour        hour;
    t_minute      minute;
    t_second      second;
    t_weekday     weekday;

    modport source (
        output valid, output year_offset, output month, output day_of_month,
        output hour, output minute, output second, output weekday, input ready
    );
    modport sink (
        input valid, input year_offset, input month, input day_of_month,
        input hour, input minute, input second, input weekday, output ready
    );
endinterface

// ===== hw/rtl/unix_time_to_calendar.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unix_time_to_calendar
// Converts a UTC seconds count since 1970 into Gregorian calendar fields.
// ----------------------------------------------------------------------------
// Usage:
//   Each input item on i_in carries one 32-bit seconds count; each result
//   item on o_out carries year minus 2000, month, day, hour, minute, second
//   and weekday (0 is Sunday). Every input item gives exactly one result.
//   The block is a 15-stage pipeline. One item is accepted every cycle
//   unless the receiver stalls while every stage holds an item.
//   Most stages come from three chained constant dividers (seconds to
//   days, then the century term, then the month term), three stages each.
//   Each stage holds a valid bit. A stage advances when it is empty or when
//   the stage after it advances, so bubbles close up while the receiver
//   stalls and i_in.ready falls only once all 15 stages hold items.
//   A stalled result stays on o_out unchanged until it is taken.
//   Synchronous reset empties the pipeline; no result is pending after it.
// ----------------------------------------------------------------------------
module unix_time_to_calendar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ut2c_in_if.sink     i_in,
    ut2c_out_if.source  o_out
);
    import ut2c_pkg::*;

    localparam int N_STAGES = 15;

    logic [N_STAGES:1]   r_v;
    logic [N_STAGES+1:1] stage_en;

    // Stage 1-3: seconds to days.
    logic [15:0] day_q;
    logic [9:0]  day_r;
    logic [C_SUBDAY_BITS-1:0] r_lo7 [1:3];

    // Stage 4.
    logic        n_gstep;
    logic [16:0] n_bb;
    logic [17:0] n_vc;
    logic [16:0] r_sod4;
    logic [17:0] r_vc4;
    logic [15:0] r_wx4;
    logic [16:0] r_bb [4:9];

    // Stage 5-7: hour, century term, weekday.
    logic [4:0]  hour_q;
    logic [11:0] hour_r;
    logic [7:0]  cen_q;
    logic [10:0] cen_r;
    logic [12:0] wd_q;
    logic [2:0]  wd_r;

    // Stage 8.
    logic [4:0]  r_hour [8:14];
    logic [11:0] r_remh8;
    logic [12:0] r_c [8:14];
    logic [2:0]  r_wd [8:14];

    // Stage 9-11: minute and second; D, W and the E dividend.
    logic [5:0]  min_q;
    logic [5:0]  min_r;
    logic [23:0] n_d_full;
    logic [21:0] r_d9;
    logic [22:0] n_w_full;
    logic [8:0]  r_w [10:14];
    logic [22:0] r_x11;

    // Stage 12-14: E term.
    logic [3:0]  e_q;
    logic [5:0]  r_min [12:14];
    logic [5:0]  r_sec [12:14];

    // Stage 15.
    t_month      n_month;
    logic [8:0]  n_day_full;
    logic [15:0] n_year_full;
    t_year_offset r_year;
    t_month       r_month;
    t_day         r_day;
    t_hour        r_hour15;
    t_minute      r_min15;
    t_second      r_sec15;
    t_weekday     r_wd15;

    // ------------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------------
    always_comb begin
        stage_en[N_STAGES+1] = o_out.ready;
        for (int k = N_STAGES; k >= 1; k--) begin
            stage_en[k] = !r_v[k] || stage_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (stage_en[1]) begin
                r_v[1] <= i_in.valid;
            end
            for (int k = 2; k <= N_STAGES; k++) begin
                if (stage_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign i_in.ready  = stage_en[1];
    assign o_out.valid = r_v[N_STAGES];

    // ------------------------------------------------------------------------
    // Stage 1-3: day count and seconds of the day
    // ------------------------------------------------------------------------
    ut2c_cdiv #(
        .W_IN    (C_TS_W - C_SUBDAY_BITS),
        .DIVISOR (C_DAY_DIV),
        .W_Q     (16)
    ) u_div_day (
        .i_clk (i_clk),
        .i_en  (stage_en[3:1]),
        .i_x   (i_in.seconds_count[C_TS_W-1:C_SUBDAY_BITS]),
        .o_q   (day_q),
        .o_r   (day_r)
    );

    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            r_lo7[1] <= i_in.seconds_count[C_SUBDAY_BITS-1:0];
        end
        for (int k = 2; k <= 3; k++) begin
            if (stage_en[k]) begin
                r_lo7[k] <= r_lo7[k-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4: Gregorian correction folded into a single day-count compare
    // ------------------------------------------------------------------------
    assign n_gstep = (day_q >= C_ALPHA_STEP_DAYS);
    assign n_bb    = 17'(day_q) + 17'(n_gstep);
    assign n_vc    = 18'({n_bb, 2'b00}) + C_CEN_BIAS;

    always_ff @(posedge i_clk) begin
        if (stage_en[4]) begin
            r_sod4   <= {day_r, r_lo7[3]};
            r_vc4    <= n_vc;
            r_wx4    <= day_q + C_WD_BIAS;
            r_bb[4]  <= n_bb;
        end
        for (int k = 5; k <= 9; k++) begin
            if (stage_en[k]) begin
                r_bb[k] <= r_bb[k-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 5-7: hour, century term C and weekday in parallel
    // ------------------------------------------------------------------------
    ut2c_cdiv #(.W_IN(17), .DIVISOR(3600), .W_Q(5)) u_div_hour (
        .i_clk (i_clk),
        .i_en  (stage_en[7:5]),
        .i_x   (r_sod4),
        .o_q   (hour_q),
        .o_r   (hour_r)
    );

    ut2c_cdiv #(.W_IN(18), .DIVISOR(1461), .W_Q(8)) u_div_cen (
        .i_clk (i_clk),
        .i_en  (stage_en[7:5]),
        .i_x   (r_vc4),
        .o_q   (cen_q),
        .o_r   (cen_r)
    );

    ut2c_cdiv #(.W_IN(16), .DIVISOR(7), .W_Q(13)) u_div_wd (
        .i_clk (i_clk),
        .i_en  (stage_en[7:5]),
        .i_x   (r_wx4),
        .o_q   (wd_q),
        .o_r   (wd_r)
    );

    // ------------------------------------------------------------------------
    // Stage 8 and the delay lines that carry fields to the output stage
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (stage_en[8]) begin
            r_hour[8] <= hour_q;
            r_remh8   <= hour_r;
            r_c[8]    <= C_CEN_BASE + 13'(cen_q);
            // The weekday quotient only sizes the divider; the remainder counts.
            r_wd[8]   <= (wd_q[0] == wd_q[0]) ? wd_r : wd_r;
        end
        for (int k = 9; k <= 14; k++) begin
            if (stage_en[k]) begin
                r_hour[k] <= r_hour[k-1];
                r_c[k]    <= r_c[k-1];
                r_wd[k]   <= r_wd[k-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 9-11: minute and second; D = floor(1461 * C / 4), W = B - D
    // ------------------------------------------------------------------------
    ut2c_cdiv #(.W_IN(12), .DIVISOR(60), .W_Q(6)) u_div_min (
        .i_clk (i_clk),
        .i_en  (stage_en[11:9]),
        .i_x   (r_remh8),
        .o_q   (min_q),
        .o_r   (min_r)
    );

    assign n_d_full = 24'(r_c[8]) * C_CYCLE_DAYS;
    // B - D always lies between 122 and 488, so nine bits hold it.
    assign n_w_full = 23'(r_bb[9]) + C_JD_B_BASE - 23'(r_d9);

    always_ff @(posedge i_clk) begin
        if (stage_en[9]) begin
            r_d9 <= n_d_full[23:2];
        end
        if (stage_en[10]) begin
            r_w[10] <= n_w_full[8:0];
        end
        if (stage_en[11]) begin
            r_x11 <= 23'(r_w[10]) * C_E_NUM;
        end
        for (int k = 11; k <= 14; k++) begin
            if (stage_en[k]) begin
                r_w[k] <= r_w[k-1];
            end
        end
        if (stage_en[12]) begin
            r_min[12] <= min_q;
            r_sec[12] <= min_r;
        end
        for (int k = 13; k <= 14; k++) begin
            if (stage_en[k]) begin
                r_min[k] <= r_min[k-1];
                r_sec[k] <= r_sec[k-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 12-14: month term E
    // ------------------------------------------------------------------------
    ut2c_cdiv #(.W_IN(23), .DIVISOR(C_E_DEN), .W_Q(4)) u_div_e (
        .i_clk (i_clk),
        .i_en  (stage_en[14:12]),
        .i_x   (r_x11),
        .o_q   (e_q),
        .o_r   ()
    );

    // ------------------------------------------------------------------------
    // Stage 15: day, month and year from E, W and C
    // ------------------------------------------------------------------------
    assign n_month     = (e_q < 4'd14) ? (e_q - 4'd1) : (e_q - 4'd13);
    assign n_day_full  = r_w[14] - f_month_start(e_q);
    assign n_year_full = 16'(r_c[14])
                       - ((n_month > 4'd2) ? C_YEAR_SUB_LATE : C_YEAR_SUB_EARLY);

    always_ff @(posedge i_clk) begin
        if (stage_en[15]) begin
            r_year   <= t_year_offset'(n_year_full[7:0]);
            r_month  <= n_month;
            r_day    <= n_day_full[4:0];
            r_hour15 <= r_hour[14];
            r_min15  <= r_min[14];
            r_sec15  <= r_sec[14];
            r_wd15   <= r_wd[14];
        end
    end

    assign o_out.year_offset  = r_year;
    assign o_out.month        = r_month;
    assign o_out.day_of_month = r_day;
    assign o_out.hour         = r_hour15;
    assign o_out.minute       = r_min15;
    assign o_out.second       = r_sec15;
    assign o_out.weekday      = r_wd15;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_accept_fills_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_v[1])
        else $error("accepted item did not enter the first stage");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.month >= 4'd1 && o_out.month <= 4'd12))
        else $error("month out of range");

    a_day_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.day_of_month >= 5'd1))
        else $error("day of month is zero");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.hour <= 5'd23 && o_out.minute <= 6'd59
                         && o_out.second <= 6'd59))
        else $error("time of day out of range");

    a_weekday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.weekday <= 3'd6))
        else $error("weekday out of range");

endmodule

// ===== hw/rtl/ut2c_cdiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ut2c_cdiv
// Three-stage divider by a constant: reciprocal multiply, back multiply,
// then a single compare-and-subtract correction.
// ----------------------------------------------------------------------------
module ut2c_cdiv #(
    parameter int W_IN    = 16,
    parameter int DIVISOR = 3,
    parameter int W_Q     = 8
) (
    input  logic                       i_clk,
    input  logic [2:0]                 i_en,
    input  logic [W_IN-1:0]            i_x,
    output logic [W_Q-1:0]             o_q,
    output logic [$clog2(DIVISOR)-1:0] o_r
);

    localparam int              W_R   = $clog2(DIVISOR);
    localparam longint unsigned RECIP = (64'd1 << W_IN) / DIVISOR;
    localparam int              W_M   = $clog2(RECIP + 1);
    localparam int              W_P   = W_IN + W_M;

    localparam logic [W_M-1:0]  C_RECIP = W_M'(RECIP);
    localparam logic [W_IN-1:0] C_DIV_X = W_IN'(DIVISOR);
    localparam logic [W_R:0]    C_DIV_R = (W_R + 1)'(DIVISOR);

    logic [W_P-1:0]  prod;
    logic [W_IN-1:0] back;

    logic [W_IN-1:0] r_x1;
    logic [W_Q-1:0]  r_q1;
    logic [W_Q-1:0]  r_q2;
    logic [W_R:0]    r_rr2;
    logic [W_Q-1:0]  r_q3;
    logic [W_R-1:0]  r_r3;

    // With a shift of W_IN the estimate is the true quotient or one less.
    assign prod = W_P'(i_x) * W_P'(C_RECIP);
    assign back = r_x1 - W_IN'(W_IN'(r_q1) * C_DIV_X);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x1 <= i_x;
            r_q1 <= prod[W_IN +: W_Q];
        end
        if (i_en[1]) begin
            r_q2  <= r_q1;
            r_rr2 <= back[W_R:0];
        end
        if (i_en[2]) begin
            if (r_rr2 >= C_DIV_R) begin
                r_q3 <= r_q2 + W_Q'(1);
                r_r3 <= W_R'(r_rr2 - C_DIV_R);
            end else begin
                r_q3 <= r_q2;
                r_r3 <= r_rr2[W_R-1:0];
            end
        end
    end

    assign o_q = r_q3;
    assign o_r = r_r3;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the seconds-to-calendar converter. Directed dates
// around leap days, year ends and the 2100 correction step are followed by
// random timestamps. The random items run under four handshake mixes:
// free flow, sender gaps, receiver stalls, and both. Every result is
// compared field by field with a behavioral date conversion.
// ----------------------------------------------------------------------------
module testbench;
    import ut2c_pkg::*;

    localparam longint unsigned SECS_PER_HOUR   = 3600;
    localparam longint unsigned SECS_PER_DAY    = 86400;
    localparam longint unsigned EPOCH_JD_X10    = 24405875;
    localparam longint unsigned GREGORIAN_JD    = 2299161;
    localparam longint unsigned ALPHA_BIAS      = 186721625;
    localparam longint unsigned ALPHA_DIV       = 3652425;
    localparam longint unsigned CENT_BIAS       = 12210;
    localparam longint unsigned DAYS_PER_CENT   = 36525;
    localparam longint unsigned MONTH_SCALE     = 306001;
    localparam longint unsigned B_OFFSET        = 1524;
    localparam int              YEAR_SUB_LATE   = 4716;
    localparam int              YEAR_SUB_EARLY  = 4715;
    localparam int unsigned     LAST_FULL_DAY   = 49709;
    localparam int              PIPE_DEPTH      = 15;
    localparam int              ITEMS_PER_PHASE = 282;
    localparam int              CYCLE_LIMIT     = 200000;

    typedef struct packed {
        t_year_offset year_offset;
        t_month       month;
        t_day         day_of_month;
        t_hour        hour;
        t_minute      minute;
        t_second      second;
        t_weekday     weekday;
    } cal_fields_t;

    logic i_clk;
    logic i_rst_n;

    ut2c_in_if  in_ch ();
    ut2c_out_if out_ch ();

    unix_time_to_calendar dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    cal_fields_t pending_dates[$];
    int          src_gap_pct;
    int          sink_stall_pct;
    int          sent_count;
    int          checked_count;
    int          error_count;
    int          cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Meeus conversion in scaled integers: day count to Julian day, then the
    // Gregorian correction, then the century and month terms.
    function automatic cal_fields_t to_calendar(input t_seconds_count secs);
        longint unsigned ts, in_hour, days, jd10, jd, alpha;
        longint unsigned b, c, d, e, dom, mon;
        int          yr;
        cal_fields_t r;
        ts      = secs;
        in_hour = ts % SECS_PER_HOUR;
        days    = ts / SECS_PER_DAY;
        jd10    = days * 10 + EPOCH_JD_X10;
        jd      = (jd10 + 5) / 10;
        if (jd >= GREGORIAN_JD) begin
            alpha = (jd * 100 - ALPHA_BIAS) / ALPHA_DIV;
            jd    = jd + 1 + alpha - alpha / 4;
        end
        b   = jd + B_OFFSET;
        c   = (b * 100 - CENT_BIAS) / DAYS_PER_CENT;
        d   = (DAYS_PER_CENT * c) / 100;
        e   = ((b - d) * 10000) / MONTH_SCALE;
        dom = b - d - (MONTH_SCALE * e) / 10000;
        mon = (e < 14) ? e - 1 : e - 13;
        yr  = int'(c) - ((mon > 2) ? YEAR_SUB_LATE : YEAR_SUB_EARLY);

        r.year_offset  = t_year_offset'(yr - C_BASE_YEAR);
        r.month        = t_month'(mon);
        r.day_of_month = t_day'(dom);
        r.hour         = t_hour'((ts / SECS_PER_HOUR) % 24);
        r.minute       = t_minute'(in_hour / 60);
        r.second       = t_second'(in_hour % 60);
        r.weekday      = t_weekday'(((jd10 + 15) / 10) % 7);
        return r;
    endfunction

    task automatic send_seconds(input t_seconds_count secs);
        while ($urandom_range(99) < src_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.seconds_count <= secs;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_dates.push_back(to_calendar(secs));
        sent_count++;
    endtask

    // Mixes uniform counts with counts sitting right on day and hour edges.
    task automatic run_random_stream(input int count);
        longint unsigned secs;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(3))
                0, 1: secs = $urandom();
                2: begin
                    secs = longint'($urandom_range(LAST_FULL_DAY)) * SECS_PER_DAY;
                    case ($urandom_range(3))
                        0: secs += 0;
                        1: secs += 1;
                        2: secs += SECS_PER_DAY - 2;
                        default: secs += SECS_PER_DAY - 1;
                    endcase
                end
                default: begin
                    secs = longint'($urandom_range(LAST_FULL_DAY)) * SECS_PER_DAY
                         + longint'($urandom_range(23)) * SECS_PER_HOUR
                         + ($urandom_range(1) ? SECS_PER_HOUR - 1 : 0);
                end
            endcase
            send_seconds(t_seconds_count'(secs));
        end
    endtask

    task automatic test_calendar_corners();
        t_seconds_count corners[$];
        corners = '{
            32'd0, 32'd86399, 32'd86400,
            32'd68169599, 32'd68169600,          // into 1972-02-29
            32'd946684799, 32'd946684800,        // 1999 into 2000
            32'd951782399, 32'd951782400,        // 2000-02-29
            32'd951868800,
            32'd1719791999, 32'd1719792000,      // end of June
            32'd1234567890,
            32'd2147483647, 32'd2147483648,      // signed 32-bit rollover
            32'd4107542399, 32'd4107542400,      // 2100 is not a leap year
            32'd4133980799, 32'd4133980800,
            32'hFFFF_FFFF
        };
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        foreach (corners[i]) send_seconds(corners[i]);
    endtask

    task automatic test_random_free_flow();
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        run_random_stream(ITEMS_PER_PHASE);
    endtask

    task automatic test_random_sender_gaps();
        src_gap_pct    = 69;
        sink_stall_pct = 0;
        run_random_stream(ITEMS_PER_PHASE);
    endtask

    task automatic test_random_receiver_stalls();
        src_gap_pct    = 0;
        sink_stall_pct = 69;
        run_random_stream(ITEMS_PER_PHASE);
    endtask

    task automatic test_random_both_idle();
        src_gap_pct    = 37;
        sink_stall_pct = 37;
        run_random_stream(ITEMS_PER_PHASE);
    endtask

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        cal_fields_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_dates.size() == 0) begin
                $error("result item arrived with no timestamp outstanding");
                error_count++;
            end else begin
                want = pending_dates.pop_front();
                checked_count++;
                if (out_ch.year_offset !== want.year_offset) begin
                    $error("year_offset: expected %0d, actual %0d",
                           want.year_offset, out_ch.year_offset);
                    error_count++;
                end
                if (out_ch.month !== want.month) begin
                    $error("month: expected %0d, actual %0d", want.month, out_ch.month);
                    error_count++;
                end
                if (out_ch.day_of_month !== want.day_of_month) begin
                    $error("day_of_month: expected %0d, actual %0d",
                           want.day_of_month, out_ch.day_of_month);
                    error_count++;
                end
                if (out_ch.hour !== want.hour) begin
                    $error("hour: expected %0d, actual %0d", want.hour, out_ch.hour);
                    error_count++;
                end
                if (out_ch.minute !== want.minute) begin
                    $error("minute: expected %0d, actual %0d", want.minute, out_ch.minute);
                    error_count++;
                end
                if (out_ch.second !== want.second) begin
                    $error("second: expected %0d, actual %0d", want.second, out_ch.second);
                    error_count++;
                end
                if (out_ch.weekday !== want.weekday) begin
                    $error("weekday: expected %0d, actual %0d",
                           want.weekday, out_ch.weekday);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_dates.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.seconds_count = '0;
        out_ch.ready        = 1'b0;
        src_gap_pct         = 0;
        sink_stall_pct      = 0;
        sent_count          = 0;
        checked_count       = 0;
        error_count         = 0;
        cycle_count         = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_calendar_corners();
        test_random_free_flow();
        test_random_sender_gaps();
        test_random_receiver_stalls();
        test_random_both_idle();
        // Valid stays high between items except in sender gaps, and drops after the last item.
        in_ch.valid <= 1'b0;

        // Drain with free flow so the tail empties quickly.
        sink_stall_pct = 0;
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (2 * PIPE_DEPTH) @(posedge i_clk);

        if (pending_dates.size() != 0) begin
            $error("%0d expected results never arrived", pending_dates.size());
            error_count++;
        end
        $display("Converted %0d timestamps (calendar corners plus four idling mixes),",
                 sent_count);
        $display("checked %0d result items with %0d field errors.",
                 checked_count, error_count);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== unix_time_to_calendar.f =====
hw/rtl/ut2c_pkg.sv
hw/rtl/ut2c_in_if.sv
hw/rtl/ut2c_out_if.sv
hw/rtl/ut2c_cdiv.sv
hw/rtl/unix_time_to_calendar.sv
dv/testbench.sv
